[rtl/mcle_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mcle_pkg
// Shared types, character constants and the letter pattern table of the
// morse light encoder.
// ----------------------------------------------------------------------------
package mcle_pkg;

  localparam int unsigned CharW = 8;
  localparam int unsigned DurW  = 16;
  localparam int unsigned IdxW  = 2;

  // register indexes on the configuration channel
  localparam logic [IdxW-1:0] CFG_DOT   = 2'd0;
  localparam logic [IdxW-1:0] CFG_DASH  = 2'd1;
  localparam logic [IdxW-1:0] CFG_SPACE = 2'd2;

  localparam logic [DurW-1:0] DOT_RESET   = 16'd200;
  localparam logic [DurW-1:0] DASH_RESET  = 16'd600;
  localparam logic [DurW-1:0] SPACE_RESET = 16'd1400;

  localparam logic [CharW-1:0] CHAR_SPACE  = 8'h20;
  localparam logic [CharW-1:0] CHAR_UA     = 8'h41;
  localparam logic [CharW-1:0] CHAR_UZ     = 8'h5A;
  localparam logic [CharW-1:0] CHAR_LA     = 8'h61;
  localparam logic [CharW-1:0] CHAR_LZ     = 8'h7A;
  localparam logic [CharW-1:0] CASE_OFFSET = 8'h20;

  localparam logic [2:0] MAX_ELEMS = 3'd4;

  typedef enum logic [1:0] {
    S_IDLE,
    S_LIT,
    S_GAP,
    S_SPACE
  } mcle_state_t;

  typedef enum logic [1:0] {
    SEG_NONE,
    SEG_LIT,
    SEG_GAP,
    SEG_SPACE
  } mcle_seg_t;

  typedef struct packed {
    logic      load;
    logic      shift;
    mcle_seg_t seg;
  } mcle_cmd_t;

  typedef struct packed {
    logic is_space;
    logic is_letter;
    logic last_elem;
  } mcle_sts_t;

  // bits 7..4 elements (first in bit 7, 1 = dash), bits 3..0 element count
  function automatic logic [7:0] letter_code(input logic [4:0] idx);
    logic [7:0] code;
    case (idx)
      5'd0:    code = 8'h42;
      5'd1:    code = 8'h84;
      5'd2:    code = 8'hA4;
      5'd3:    code = 8'h83;
      5'd4:    code = 8'h01;
      5'd5:    code = 8'h24;
      5'd6:    code = 8'hC3;
      5'd7:    code = 8'h04;
      5'd8:    code = 8'h02;
      5'd9:    code = 8'h74;
      5'd10:   code = 8'hA3;
      5'd11:   code = 8'h44;
      5'd12:   code = 8'hC2;
      5'd13:   code = 8'h82;
      5'd14:   code = 8'hE3;
      5'd15:   code = 8'h64;
      5'd16:   code = 8'hD4;
      5'd17:   code = 8'h43;
      5'd18:   code = 8'h03;
      5'd19:   code = 8'h81; // single dash
      5'd20:   code = 8'h23;
      5'd21:   code = 8'h14;
      5'd22:   code = 8'h63;
      5'd23:   code = 8'h94;
      5'd24:   code = 8'hB4;
      5'd25:   code = 8'hC4;
      default: code = 8'h00;
    endcase
    return code;
  endfunction

endpackage
`default_nettype wire

[rtl/mcle_ifs.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mcle channel interfaces
// Valid/ready channels for characters, light segments and register writes.
// ----------------------------------------------------------------------------
interface mcle_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  modport source (output valid, output char_code, input ready);
  modport sink   (input valid, input char_code, output ready);
endinterface

interface mcle_seg_if;
  logic        valid;
  logic        ready;
  logic        light_on;
  logic [15:0] duration;
  logic        last;
  modport source (output valid, output light_on, output duration, output last, input ready);
  modport sink   (input valid, input light_on, input duration, input last, output ready);
endinterface

interface mcle_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [15:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

[rtl/mcle_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mcle_ctrl
// Sequencer: walks a character through its lit and dark segments.
// ----------------------------------------------------------------------------
module mcle_ctrl
  import mcle_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_ready,
  output logic           out_valid,
  input  wire logic      out_ready,
  input  wire mcle_sts_t sts,
  output mcle_cmd_t      cmd
);

  mcle_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    in_ready  = 1'b0;
    out_valid = 1'b0;
    cmd.load  = 1'b0;
    cmd.shift = 1'b0;
    cmd.seg   = SEG_NONE;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load = 1'b1;
          if (sts.is_space) begin
            state_nxt = S_SPACE;
          end else if (sts.is_letter) begin
            state_nxt = S_LIT;
          end
        end
      end
      S_LIT: begin
        out_valid = 1'b1;
        cmd.seg   = SEG_LIT;
        if (out_ready) begin
          state_nxt = S_GAP;
        end
      end
      S_GAP: begin
        out_valid = 1'b1;
        cmd.seg   = SEG_GAP;
        if (out_ready) begin
          cmd.shift = 1'b1;
          state_nxt = sts.last_elem ? S_IDLE : S_LIT;
        end
      end
      S_SPACE: begin
        out_valid = 1'b1;
        cmd.seg   = SEG_SPACE;
        if (out_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid))
    else $error("new character taken while a segment is pending");

  a_lit_then_gap: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_LIT) && out_ready |=> state_r == S_GAP)
    else $error("lit segment not followed by its gap");

  a_last_gap_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_GAP) && out_ready && sts.last_elem |=> state_r == S_IDLE)
    else $error("final gap did not end the character");

  a_space_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SPACE) && out_ready |=> state_r == S_IDLE)
    else $error("space segment did not end the character");

endmodule
`default_nettype wire

[rtl/mcle_dp.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mcle_dp
// Datapath: timing registers, character decode, pattern shifter and
// segment payload.
// ----------------------------------------------------------------------------
module mcle_dp
  import mcle_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic [CharW-1:0]  in_char_code,
  input  wire logic              cfg_we,
  input  wire logic [IdxW-1:0]   cfg_index,
  input  wire logic [DurW-1:0]   cfg_data,
  input  wire mcle_cmd_t         cmd,
  output mcle_sts_t              sts,
  output logic                   out_light_on,
  output logic [DurW-1:0]        out_duration,
  output logic                   out_last
);

  logic [DurW-1:0]  dot_len_r, dash_len_r, space_len_r;
  logic [3:0]       pat_r;
  logic [2:0]       cnt_r;
  logic [CharW-1:0] upper;
  logic [CharW-1:0] offs;
  logic [7:0]       code;
  logic [2:0]       len;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dot_len_r   <= DOT_RESET;
      dash_len_r  <= DASH_RESET;
      space_len_r <= SPACE_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_DOT:   dot_len_r   <= cfg_data;
        CFG_DASH:  dash_len_r  <= cfg_data;
        CFG_SPACE: space_len_r <= cfg_data;
        default:   ;
      endcase
    end
  end

  // fold lower case, then look up the pattern
  always_comb begin
    upper = in_char_code;
    if (in_char_code >= CHAR_LA && in_char_code <= CHAR_LZ) begin
      upper = in_char_code - CASE_OFFSET;
    end
    offs = upper - CHAR_UA;
    code = letter_code(offs[4:0]);
    len  = (code[3:0] > {1'b0, MAX_ELEMS}) ? MAX_ELEMS : code[2:0];
    sts.is_space  = (upper == CHAR_SPACE);
    sts.is_letter = (upper >= CHAR_UA) && (upper <= CHAR_UZ) && (len != 3'd0);
    sts.last_elem = (cnt_r == 3'd1);
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      pat_r <= code[7:4];
      cnt_r <= len;
    end else if (cmd.shift) begin
      pat_r <= {pat_r[2:0], 1'b0};
      cnt_r <= cnt_r - 3'd1;
    end
  end

  always_comb begin
    out_light_on = (cmd.seg == SEG_LIT);
    out_last     = (cmd.seg == SEG_SPACE) || ((cmd.seg == SEG_GAP) && (cnt_r == 3'd1));
    case (cmd.seg)
      SEG_LIT:   out_duration = pat_r[3] ? dash_len_r : dot_len_r;
      SEG_GAP:   out_duration = dash_len_r;
      SEG_SPACE: out_duration = space_len_r;
      default:   out_duration = '0;
    endcase
  end

endmodule
`default_nettype wire

[rtl/morse_code_light_encoder_core.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// morse_code_light_encoder_core
// Turns characters into a stream of timed lamp segments.
// ----------------------------------------------------------------------------
// Usage:
//   in_if   : one ASCII character per request. Letters of either case give a
//             lit segment (dot or dash length) and a dark gap of dash length
//             per element; space gives one dark segment; anything else
//             gives nothing.
//   out_if  : one segment per request: light_on, duration, last. last marks
//             the final segment of a character.
//   cfg_if  : register writes, index 0 dot, 1 dash, 2 space length; always
//             ready, other indexes ignored. Write only while idle.
// Timing: a character is taken while idle and its first segment is offered
//   from the next cycle, one segment per cycle while out_if is ready. The
//   sequencer holds one character at a time, so in_if.ready drops until the
//   last segment has been taken.
// Stall: a segment is held unchanged until out_if.ready.
// Reset: sequencer back to idle, lengths back to 200, 600 and 1400.
// ----------------------------------------------------------------------------
module morse_code_light_encoder_core
  import mcle_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  mcle_char_if.sink in_if,
  mcle_seg_if.source out_if,
  mcle_cfg_if.sink  cfg_if
);

  mcle_cmd_t cmd;
  mcle_sts_t sts;

  assign cfg_if.ready = 1'b1;

  mcle_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_if.valid),
    .in_ready  (in_if.ready),
    .out_valid (out_if.valid),
    .out_ready (out_if.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  mcle_dp u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_char_code (in_if.char_code),
    .cfg_we       (cfg_if.valid),
    .cfg_index    (cfg_if.index),
    .cfg_data     (cfg_if.data),
    .cmd          (cmd),
    .sts          (sts),
    .out_light_on (out_if.light_on),
    .out_duration (out_if.duration),
    .out_last     (out_if.last)
  );

endmodule
`default_nettype wire
